FILE: hdl/obstacle_avoid_drive_fsm_core_assert.svh
// Assertion macros for the checker file of the drive core.
// Each macro names the clock clk_i and the active-low reset rst_ni of the
// module that uses it.
`ifndef OBSTACLE_AVOID_DRIVE_FSM_CORE_ASSERT_SVH
`define OBSTACLE_AVOID_DRIVE_FSM_CORE_ASSERT_SVH

// Same-cycle implication.
`define OADF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define OADF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/oadf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package oadf_pkg;

  localparam int DIST_W    = 16;
  localparam int VOLT_W    = 14;
  localparam int SENS_W    = 16;
  localparam int FRAC_W    = 12;
  localparam int ACC_W     = 44;
  localparam int HALF_W    = 22;
  localparam int PLO_W     = HALF_W + SENS_W;
  localparam int PHI_W     = ACC_W - HALF_W + SENS_W + 1;
  localparam int PROD_W    = PHI_W + HALF_W;
  localparam int PEDAL_W   = 7;
  localparam int OUT_W     = 8;
  localparam int IDX_W     = 3;
  localparam int CFG_DW    = 16;
  localparam int IN_TW     = 64;
  localparam int OUT_TW    = 24;
  localparam int COEF_IW   = 4;

  localparam logic [COEF_IW-1:0] POLY_LAST = 4'd8;

  localparam logic [DIST_W-1:0] HALF_METER  = 16'd2048;
  localparam logic [DIST_W-1:0] WIDE_OPEN   = 16'd1638;
  localparam logic [DIST_W:0]   SIDE_MARGIN = 17'd41;

  localparam logic signed [OUT_W-1:0] TURN_PEDAL     = 8'sd5;
  localparam logic signed [OUT_W-1:0] REV_PEDAL      = -8'sd10;
  localparam logic signed [OUT_W-1:0] REV_TURN_PEDAL = -8'sd5;

  typedef enum logic [2:0] {
    MODE_FWD       = 3'd0,
    MODE_LEFT      = 3'd1,
    MODE_RIGHT     = 3'd2,
    MODE_REV       = 3'd3,
    MODE_REV_LEFT  = 3'd4,
    MODE_REV_RIGHT = 3'd5
  } oadf_mode_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_DANGER  = 3'd0,
    CFG_TURN    = 3'd1,
    CFG_SIDE    = 3'd2,
    CFG_RECOVER = 3'd3,
    CFG_FWD_PED = 3'd4,
    CFG_STEER   = 3'd5
  } oadf_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_SAT,
    ST_DONE
  } oadf_state_e;

  typedef struct packed {
    logic [DIST_W-1:0]  danger;
    logic [DIST_W-1:0]  turn;
    logic [DIST_W-1:0]  side;
    logic [DIST_W-1:0]  recover;
    logic [PEDAL_W-1:0] fwd_pedal;
    logic [PEDAL_W-1:0] steer_mag;
  } oadf_cfg_t;

  localparam oadf_cfg_t CFG_RESET = '{
    danger:    16'd819,
    turn:      16'd3277,
    side:      16'd1229,
    recover:   16'd2867,
    fwd_pedal: 7'd20,
    steer_mag: 7'd40
  };

  typedef struct packed {
    logic               load;
    logic               mul_lo;
    logic               mul_hi;
    logic               acc_step;
    logic               sat;
    logic               commit;
    logic [COEF_IW-1:0] coef_idx;
  } oadf_cmd_t;

  // Q12 polynomial coefficients, highest power first.
  function automatic logic signed [ACC_W-1:0] oadf_coef(input logic [COEF_IW-1:0] idx);
    logic signed [ACC_W-1:0] c;
    case (idx)
      4'd0:    c = 44'sd27599;
      4'd1:    c = -44'sd803796;
      4'd2:    c = 44'sd7098440;
      4'd3:    c = -44'sd30635196;
      4'd4:    c = 44'sd75413586;
      4'd5:    c = -44'sd112306684;
      4'd6:    c = 44'sd102592676;
      4'd7:    c = -44'sd56270782;
      4'd8:    c = 44'sd17045651;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/oadf_ir_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// One infrared conversion lane: Horner evaluation on one multiplier shared by
// the low and high accumulator halves.
module oadf_ir_lane (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire oadf_pkg::oadf_cmd_t     cmd_i,
  input  wire [oadf_pkg::VOLT_W-1:0]   volt_i,
  output logic [oadf_pkg::DIST_W-1:0]  dist_o
);

  logic [oadf_pkg::SENS_W-1:0]        sens;
  logic signed [oadf_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [oadf_pkg::PLO_W-1:0]         plo_q, plo_d;
  logic signed [oadf_pkg::PHI_W-1:0]  phi_q, phi_d;
  logic signed [oadf_pkg::PROD_W-1:0] prod;
  logic [oadf_pkg::DIST_W-1:0]        dist_q, dist_d;
  logic signed [oadf_pkg::HALF_W:0]   mul_a;
  logic signed [oadf_pkg::PHI_W:0]    mul_p;

  // Undo the divider: sensor voltage is twice the input.
  assign sens = {1'b0, volt_i, 1'b0};

  always_comb begin
    // Signed top half in the high phase, unsigned bottom half otherwise.
    if (cmd_i.mul_hi) begin
      mul_a = {acc_q[oadf_pkg::ACC_W-1], acc_q[oadf_pkg::ACC_W-1:oadf_pkg::HALF_W]};
    end else begin
      mul_a = {1'b0, acc_q[oadf_pkg::HALF_W-1:0]};
    end
    mul_p = mul_a * $signed({1'b0, sens});
    plo_d = mul_p[oadf_pkg::PLO_W-1:0];
    phi_d = mul_p[oadf_pkg::PHI_W-1:0];
    prod  = $signed({phi_q, {oadf_pkg::HALF_W{1'b0}}})
          + $signed({{(oadf_pkg::PROD_W - oadf_pkg::PLO_W){1'b0}}, plo_q});
    acc_d = acc_q;
    if (cmd_i.load) begin
      acc_d = oadf_pkg::oadf_coef(cmd_i.coef_idx);
    end else if (cmd_i.acc_step) begin
      // Arithmetic shift floors; the sum wraps within the accumulator width.
      acc_d = $signed(prod[oadf_pkg::ACC_W+oadf_pkg::FRAC_W-1:oadf_pkg::FRAC_W])
            + oadf_pkg::oadf_coef(cmd_i.coef_idx);
    end
    if (acc_q[oadf_pkg::ACC_W-1]) begin
      dist_d = '0;
    end else if (|acc_q[oadf_pkg::ACC_W-2:oadf_pkg::FRAC_W+oadf_pkg::DIST_W]) begin
      dist_d = '1;
    end else begin
      dist_d = acc_q[oadf_pkg::FRAC_W+oadf_pkg::DIST_W-1:oadf_pkg::FRAC_W];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.mul_lo) begin
      plo_q <= plo_d;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= phi_d;
    end
    if (cmd_i.sat) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

  // Reset is not needed by the lane's payload registers.
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule
`default_nettype wire

FILE: hdl/oadf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Sample registers, two conversion lanes, mode decision and output register.
module oadf_datapath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire oadf_pkg::oadf_cmd_t      cmd_i,
  input  wire oadf_pkg::oadf_cfg_t      cfg_i,
  input  wire [oadf_pkg::IN_TW-1:0]     in_data_i,
  input  wire                           m_tready_i,
  output logic                          m_tvalid_o,
  output logic [oadf_pkg::OUT_TW-1:0]   m_tdata_o,
  output logic                          out_free_o
);

  logic [oadf_pkg::DIST_W-1:0] front_q, rear_q;
  logic [oadf_pkg::VOLT_W-1:0] lvolt_q, rvolt_q;
  logic                        coin_q;
  logic [oadf_pkg::DIST_W-1:0] ldist, rdist;

  oadf_pkg::oadf_mode_e        mode_q, mode_d;
  logic signed [oadf_pkg::OUT_W-1:0] pedal_d, steer_d, pedal_q, steer_q;
  logic [oadf_pkg::OUT_W-1:0]  mag;
  logic                        ovalid_q, ovalid_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      front_q <= in_data_i[15:0];
      rear_q  <= in_data_i[31:16];
      lvolt_q <= in_data_i[45:32];
      rvolt_q <= in_data_i[59:46];
      coin_q  <= in_data_i[60];
    end
  end

  oadf_ir_lane u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .volt_i (lvolt_q),
    .dist_o (ldist)
  );

  oadf_ir_lane u_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .volt_i (rvolt_q),
    .dist_o (rdist)
  );

  assign mag = {1'b0, cfg_i.steer_mag};

  always_comb begin
    mode_d  = mode_q;
    pedal_d = '0;
    steer_d = '0;
    case (mode_q)
      oadf_pkg::MODE_FWD: begin
        if (front_q < cfg_i.danger ||
            (front_q < oadf_pkg::HALF_METER && ldist < cfg_i.side && rdist < cfg_i.side)) begin
          mode_d = oadf_pkg::MODE_REV;
        end else if (front_q < cfg_i.turn) begin
          if (ldist > oadf_pkg::WIDE_OPEN && rdist > oadf_pkg::WIDE_OPEN) begin
            mode_d = coin_q ? oadf_pkg::MODE_LEFT : oadf_pkg::MODE_RIGHT;
          end else if (ldist > rdist) begin
            mode_d = oadf_pkg::MODE_LEFT;
          end else begin
            mode_d = oadf_pkg::MODE_RIGHT;
          end
        end else if (ldist < cfg_i.danger) begin
          mode_d = oadf_pkg::MODE_RIGHT;
        end else if (rdist < cfg_i.danger) begin
          mode_d = oadf_pkg::MODE_LEFT;
        end else begin
          pedal_d = {1'b0, cfg_i.fwd_pedal};
        end
      end
      oadf_pkg::MODE_LEFT: begin
        if (front_q < cfg_i.danger) begin
          mode_d = oadf_pkg::MODE_REV;
        end else if (front_q > cfg_i.turn && rdist > cfg_i.side) begin
          mode_d = oadf_pkg::MODE_FWD;
        end else if ({1'b0, rdist} > {1'b0, ldist} + oadf_pkg::SIDE_MARGIN) begin
          mode_d = oadf_pkg::MODE_RIGHT;
        end else begin
          pedal_d = oadf_pkg::TURN_PEDAL;
          steer_d = mag;
        end
      end
      oadf_pkg::MODE_RIGHT: begin
        if (front_q < cfg_i.danger) begin
          mode_d = oadf_pkg::MODE_REV;
        end else if (front_q > cfg_i.turn && ldist > cfg_i.side) begin
          mode_d = oadf_pkg::MODE_FWD;
        end else if ({1'b0, ldist} > {1'b0, rdist} + oadf_pkg::SIDE_MARGIN) begin
          mode_d = oadf_pkg::MODE_LEFT;
        end else begin
          pedal_d = oadf_pkg::TURN_PEDAL;
          steer_d = 8'd0 - mag;
        end
      end
      oadf_pkg::MODE_REV: begin
        if (rear_q < cfg_i.danger) begin
          if (front_q > rear_q) begin
            mode_d = oadf_pkg::MODE_FWD;
          end
        end else if (ldist > cfg_i.side && front_q > cfg_i.danger) begin
          mode_d = oadf_pkg::MODE_REV_LEFT;
        end else if (rdist > cfg_i.side && front_q > cfg_i.danger) begin
          mode_d = oadf_pkg::MODE_REV_RIGHT;
        end else begin
          pedal_d = oadf_pkg::REV_PEDAL;
        end
      end
      oadf_pkg::MODE_REV_LEFT: begin
        if (rear_q < cfg_i.danger) begin
          if (front_q > rear_q) begin
            mode_d = oadf_pkg::MODE_FWD;
          end
        end else if (front_q > cfg_i.recover) begin
          mode_d = oadf_pkg::MODE_FWD;
        end else if (rdist > ldist) begin
          mode_d = oadf_pkg::MODE_REV_RIGHT;
        end else begin
          pedal_d = oadf_pkg::REV_TURN_PEDAL;
          steer_d = 8'd0 - mag;
        end
      end
      oadf_pkg::MODE_REV_RIGHT: begin
        if (rear_q < cfg_i.danger) begin
          if (front_q > rear_q) begin
            mode_d = oadf_pkg::MODE_FWD;
          end
        end else if (front_q > cfg_i.recover) begin
          mode_d = oadf_pkg::MODE_FWD;
        end else if (ldist > rdist) begin
          mode_d = oadf_pkg::MODE_REV_LEFT;
        end else begin
          pedal_d = oadf_pkg::REV_TURN_PEDAL;
          steer_d = mag;
        end
      end
      default: begin
        mode_d = oadf_pkg::MODE_FWD;
      end
    endcase
  end

  assign out_free_o = !ovalid_q || m_tready_i;

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_i.commit) begin
      ovalid_d = 1'b1;
    end else if (m_tready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= oadf_pkg::MODE_FWD;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (cmd_i.commit) begin
        mode_q <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pedal_q <= pedal_d;
      steer_q <= steer_d;
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = {5'b0, mode_q, steer_q, pedal_q};

endmodule
`default_nettype wire

FILE: hdl/oadf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: eight Horner steps of three phases each, then saturate and commit.
module oadf_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_tvalid_i,
  input  wire                  out_free_i,
  output logic                 s_tready_o,
  output oadf_pkg::oadf_cmd_t  cmd_o
);

  oadf_pkg::oadf_state_e                state_q, state_d;
  logic [oadf_pkg::COEF_IW-1:0]         step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oadf_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.coef_idx = step_q;
    case (state_q)
      oadf_pkg::ST_IDLE: begin
        s_tready_o     = 1'b1;
        cmd_o.coef_idx = '0;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          step_d     = 4'd1;
          state_d    = oadf_pkg::ST_MUL_LO;
        end
      end
      oadf_pkg::ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = oadf_pkg::ST_MUL_HI;
      end
      oadf_pkg::ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = oadf_pkg::ST_ADD;
      end
      oadf_pkg::ST_ADD: begin
        cmd_o.acc_step = 1'b1;
        if (step_q == oadf_pkg::POLY_LAST) begin
          state_d = oadf_pkg::ST_SAT;
        end else begin
          step_d  = step_q + 4'd1;
          state_d = oadf_pkg::ST_MUL_LO;
        end
      end
      oadf_pkg::ST_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = oadf_pkg::ST_DONE;
      end
      oadf_pkg::ST_DONE: begin
        // Hold until the output register can take the word.
        if (out_free_i) begin
          cmd_o.commit = 1'b1;
          state_d      = oadf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = oadf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/obstacle_avoid_drive_fsm_core.sv
// Obstacle-avoiding drive mode core.
// Input stream (s_t*): one word per sensor sample set. Output stream (m_t*):
// one word per input word, carrying pedal, steering and the new drive mode.
// Configuration (cfg_*): six threshold and magnitude registers, written by
// index; cfg_ready_o is always high and a write lands at the next edge.
// Each word runs through two infrared conversion lanes in parallel. A lane
// evaluates the degree-8 polynomial with one 22x16 multiplier used twice
// per Horner step (low half, high half, then add). A word is loaded, runs
// the eight Horner steps, is saturated and is then committed to the output
// register, which raises m_tvalid; the next word is accepted after commit.
// One word is in flight at a time; s_tready is high only while idle.
// A finished word waits in the output register. While it is stalled by
// m_tready the core still accepts and converts the next word, then holds
// it before the decision until the register frees up.
// Reset (rst_ni low, asynchronous) returns to forward mode, empties the
// output register and loads the configuration reset values.
`timescale 1ns / 1ps
`default_nettype none
module obstacle_avoid_drive_fsm_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // s_tdata: front_distance[15:0], rear_distance[31:16], left_voltage[45:32],
  //          right_voltage[59:46], coin_bit[60], zero fill [63:61]
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire [oadf_pkg::IN_TW-1:0]      s_tdata,
  // m_tdata: pedal_request[7:0], steer_request[15:8], drive_mode[18:16],
  //          zero fill [23:19]
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [oadf_pkg::OUT_TW-1:0]    m_tdata,
  // Configuration write channel
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [oadf_pkg::IDX_W-1:0]      cfg_index_i,
  input  wire [oadf_pkg::CFG_DW-1:0]     cfg_data_i
);

  oadf_pkg::oadf_cfg_t cfg_q, cfg_d;
  oadf_pkg::oadf_cmd_t cmd;
  logic                out_free;

  assign cfg_ready_o = 1'b1;

  // Register file: out-of-range indexes are dropped, narrow fields truncated.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        oadf_pkg::CFG_DANGER:  cfg_d.danger    = cfg_data_i;
        oadf_pkg::CFG_TURN:    cfg_d.turn      = cfg_data_i;
        oadf_pkg::CFG_SIDE:    cfg_d.side      = cfg_data_i;
        oadf_pkg::CFG_RECOVER: cfg_d.recover   = cfg_data_i;
        oadf_pkg::CFG_FWD_PED: cfg_d.fwd_pedal = cfg_data_i[oadf_pkg::PEDAL_W-1:0];
        oadf_pkg::CFG_STEER:   cfg_d.steer_mag = cfg_data_i[oadf_pkg::PEDAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= oadf_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Controller: sequences the lanes and decides when to commit.
  oadf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .out_free_i (out_free),
    .s_tready_o (s_tready),
    .cmd_o      (cmd)
  );

  // Datapath: conversion lanes, mode register and output register.
  oadf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .in_data_i  (s_tdata),
    .m_tready_i (m_tready),
    .m_tvalid_o (m_tvalid),
    .m_tdata_o  (m_tdata),
    .out_free_o (out_free)
  );

endmodule
`default_nettype wire

FILE: hdl/oadf_port_check.sv
`timescale 1ns / 1ps
`default_nettype none
`include "obstacle_avoid_drive_fsm_core_assert.svh"
// Port-level checks on the drive core.
module oadf_port_check (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         s_tvalid,
  input wire                         s_tready,
  input wire [oadf_pkg::IN_TW-1:0]   s_tdata,
  input wire                         m_tvalid,
  input wire                         m_tready,
  input wire [oadf_pkg::OUT_TW-1:0]  m_tdata,
  input wire                         cfg_valid_i,
  input wire                         cfg_ready_o,
  input wire [oadf_pkg::IDX_W-1:0]   cfg_index_i,
  input wire [oadf_pkg::CFG_DW-1:0]  cfg_data_i
);

  logic [2:0] mode;
  assign mode = m_tdata[18:16];

  `OADF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output word dropped")
  `OADF_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled word changed")
  `OADF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
  `OADF_ASSERT_NOW(a_fwd_pedal, m_tvalid && mode == oadf_pkg::MODE_FWD, !m_tdata[7], "negative forward pedal")
  `OADF_ASSERT_NOW(a_rev_pedal, m_tvalid && (mode == oadf_pkg::MODE_REV || mode == oadf_pkg::MODE_REV_LEFT || mode == oadf_pkg::MODE_REV_RIGHT), m_tdata[7] || m_tdata[7:0] == 8'd0, "positive reverse pedal")

  logic unused_ports;
  assign unused_ports = ^{s_tdata, cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i};

endmodule

bind obstacle_avoid_drive_fsm_core oadf_port_check u_oadf_port_check (.*);
`default_nettype wire
